@@ sv/rc5_block_cipher_fixed_key_assert.svh @@
// Assertion macros used by the checker file of this block.
`ifndef RC5_BLOCK_CIPHER_FIXED_KEY_ASSERT_SVH
`define RC5_BLOCK_CIPHER_FIXED_KEY_ASSERT_SVH

// Checked only outside reset.
`define RC5_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define RC5_ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/rc5_pkg.sv @@
package rc5_pkg;

  localparam int WORD_W     = 32;
  localparam int SHIFT_W    = 5;
  localparam int KEY_WORDS  = 26;
  localparam int MAX_ROUNDS = 12;
  localparam int RC5_ROUNDS = 12;

  localparam logic [WORD_W-1:0] KEY_ROM [0:KEY_WORDS-1] = '{
    32'd2612779208, 32'd439875579,  32'd1190717637, 32'd1175216261,
    32'd1895316362, 32'd676037379,  32'd1363022932, 32'd4129418530,
    32'd824510045,  32'd296237661,  32'd3559352427, 32'd1899681837,
    32'd1266233241, 32'd664380637,  32'd2811239497, 32'd3739125530,
    32'd918565270,  32'd2817507913, 32'd1638370232, 32'd990518571,
    32'd1304414838, 32'd2920685927, 32'd819424010,  32'd1125720836,
    32'd4140569649, 32'd1694786432
  };

  typedef struct packed {
    logic              op;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } rc5_beat_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                             input logic [SHIFT_W-1:0] s);
    logic [2*WORD_W-1:0] d;
    d = {v, v} << s;
    return d[2*WORD_W-1:WORD_W];
  endfunction

endpackage

@@ sv/rc5_cell.sv @@
module rc5_cell import rc5_pkg::*; #(
  parameter logic              ODD     = 1'b0,
  parameter logic [WORD_W-1:0] KEY_ENC = KEY_ROM[2],
  parameter logic [WORD_W-1:0] KEY_DEC = KEY_ROM[3]
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      up_valid,
  output logic      up_ready,
  input  rc5_beat_t up_data,
  output logic      dn_valid,
  input  logic      dn_ready,
  output rc5_beat_t dn_data
);

  // One half-round: the selected word is updated from the other one.
  logic               upd_a;
  logic [WORD_W-1:0]  x;
  logic [WORD_W-1:0]  y;
  logic [WORD_W-1:0]  pre;
  logic [SHIFT_W-1:0] amt;
  logic [WORD_W-1:0]  rot;
  logic [WORD_W-1:0]  res;
  rc5_beat_t          beat_next;

  always_comb begin
    upd_a = ~(up_data.op ^ ODD);
    x     = upd_a ? up_data.a : up_data.b;
    y     = upd_a ? up_data.b : up_data.a;
    pre   = up_data.op ? (x - KEY_DEC) : (x ^ y);
    amt   = up_data.op ? (SHIFT_W'(0) - y[SHIFT_W-1:0]) : y[SHIFT_W-1:0];
    rot   = rotl(pre, amt);
    res   = up_data.op ? (rot ^ y) : (rot + KEY_ENC);
    beat_next    = up_data;
    if (upd_a) begin
      beat_next.a = res;
    end else begin
      beat_next.b = res;
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_data <= beat_next;
    end
  end

endmodule

@@ sv/rc5_whiten.sv @@
module rc5_whiten import rc5_pkg::*; #(
  parameter logic EXIT = 1'b0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      up_valid,
  output logic      up_ready,
  input  rc5_beat_t up_data,
  output logic      dn_valid,
  input  logic      dn_ready,
  output rc5_beat_t dn_data
);

  // Encryption adds the first two subkeys on entry; decryption removes them on exit.
  logic      apply;
  rc5_beat_t beat_next;

  always_comb begin
    apply     = (up_data.op == EXIT);
    beat_next = up_data;
    if (apply) begin
      beat_next.a = EXIT ? (up_data.a - KEY_ROM[0]) : (up_data.a + KEY_ROM[0]);
      beat_next.b = EXIT ? (up_data.b - KEY_ROM[1]) : (up_data.b + KEY_ROM[1]);
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_data <= beat_next;
    end
  end

endmodule

@@ sv/rc5_block_cipher_fixed_key.sv @@
// RC5-32 block cipher with a fixed expanded key held in a constant table.
// Input channel: valid/ready carrying op (0 encrypt, 1 decrypt), word_a and
// word_b. Output channel: res_valid/res_ready carrying out_a and out_b, one
// result beat for every input beat, in order.
// The datapath is a row of 2*ROUNDS half-round cells between an entry stage,
// which adds the first two subkeys when encrypting, and an exit stage, which
// subtracts them when decrypting. Every stage is one register. A round count
// above twelve is held to twelve, as the table holds only 26 subkeys.
// One beat is accepted every cycle while the receiver does not stall. The path
// from input to result runs through one register for each half-round and one
// for each of the two whitening stages.
// Reset clears the valid bit of every stage; the block is ready in the cycle
// after reset. When the receiver stalls, beats pile up in the stages and
// ready falls only once every stage holds a beat; a stage with a free slot
// keeps taking beats.
module rc5_block_cipher_fixed_key import rc5_pkg::*; #(
  parameter int ROUNDS = RC5_ROUNDS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  output logic              ready,
  input  logic              op,
  input  logic [WORD_W-1:0] word_a,
  input  logic [WORD_W-1:0] word_b,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [WORD_W-1:0] out_a,
  output logic [WORD_W-1:0] out_b
);

  localparam int ROUND_CNT = (ROUNDS > MAX_ROUNDS) ? MAX_ROUNDS : ROUNDS;
  localparam int CELLS     = 2 * ROUND_CNT;

  rc5_beat_t in_beat;
  rc5_beat_t out_beat;
  rc5_beat_t chain_data  [0:CELLS];
  logic      chain_valid [0:CELLS];
  logic      chain_ready [0:CELLS];

  assign in_beat = '{op: op, a: word_a, b: word_b};

  rc5_whiten #(.EXIT(1'b0)) u_entry (
    .clk      (clk),
    .rst      (rst),
    .up_valid (valid),
    .up_ready (ready),
    .up_data  (in_beat),
    .dn_valid (chain_valid[0]),
    .dn_ready (chain_ready[0]),
    .dn_data  (chain_data[0])
  );

  for (genvar j = 0; j < CELLS; j++) begin : g_cell
    rc5_cell #(
      .ODD     (1'(j % 2)),
      .KEY_ENC (KEY_ROM[j + 2]),
      .KEY_DEC (KEY_ROM[CELLS + 1 - j])
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[j]),
      .up_ready (chain_ready[j]),
      .up_data  (chain_data[j]),
      .dn_valid (chain_valid[j + 1]),
      .dn_ready (chain_ready[j + 1]),
      .dn_data  (chain_data[j + 1])
    );
  end

  rc5_whiten #(.EXIT(1'b1)) u_exit (
    .clk      (clk),
    .rst      (rst),
    .up_valid (chain_valid[CELLS]),
    .up_ready (chain_ready[CELLS]),
    .up_data  (chain_data[CELLS]),
    .dn_valid (res_valid),
    .dn_ready (res_ready),
    .dn_data  (out_beat)
  );

  assign out_a = out_beat.a;
  assign out_b = out_beat.b;

endmodule

@@ sv/rc5_chk.sv @@
`include "rc5_block_cipher_fixed_key_assert.svh"

module rc5_chk (
  input logic        clk,
  input logic        rst,
  input logic        ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [31:0] out_a,
  input logic [31:0] out_b
);

  `RC5_ASSERT_ALL(a_reset_empty, rst |=> (!res_valid && ready), "stages not empty after reset")
  `RC5_ASSERT_RUN(a_take_flows, res_ready |-> ready, "input stalled while output drains")
  `RC5_ASSERT_RUN(a_res_hold, (res_valid && !res_ready) |=> res_valid, "result beat dropped")
  `RC5_ASSERT_RUN(a_res_stable, (res_valid && !res_ready) |=> ($stable(out_a) && $stable(out_b)), "stalled result changed")

endmodule

bind rc5_block_cipher_fixed_key rc5_chk u_chk (.*);
